>>> src/ffa_pkg.sv
package ffa_pkg;

    // Width of one cell map entry and its special codes.
    localparam int CELL_W = 10;
    localparam logic [CELL_W-1:0] CELL_FREE = 10'h000;
    localparam logic [CELL_W-1:0] CELL_CONT = 10'h3FF;

    // Widths of the item fields.
    localparam int SIZE_W   = 9;
    localparam int INDEX_W  = 8;
    localparam int STATUS_W = 3;

    // Request opcodes.
    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE     = 3'd0,
        STAT_NO_ROOM  = 3'd1,
        STAT_RANGE    = 3'd2,
        STAT_NOT_HEAD = 3'd3,
        STAT_ZERO     = 3'd4
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    clear;
        logic    accept;
        logic    scan;
        logic    mark;
        logic    rlook;
        logic    rhead;
        logic    rfree;
        logic    res_load;
        status_t res_code;
        logic    res_use_start;
        logic    out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic size_zero;
        logic size_big;
        logic where_oob;
        logic found;
        logic exhausted;
        logic mark_last;
        logic is_head;
        logic free_last;
        logic out_free;
    } sts_t;

endpackage

>>> src/ffa_ram.sv
module ffa_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> src/ffa_ctrl.sv
module ffa_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic          op,
    input  ffa_pkg::sts_t sts,
    output ffa_pkg::cmd_t cmd
);

    typedef enum logic [7:0] {
        S_CLEAR  = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_SCAN   = 8'b0000_0100,
        S_MARK   = 8'b0000_1000,
        S_RLOOK  = 8'b0001_0000,
        S_RWAIT  = 8'b0010_0000,
        S_RFREE  = 8'b0100_0000,
        S_RESULT = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register; reset starts the clearing pass over the cell map.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.res_code = ffa_pkg::STAT_DONE;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (op == ffa_pkg::OP_ALLOC)
                    begin
                        priority if (sts.size_zero)
                        begin
                            cmd.res_load = 1'b1;
                            cmd.res_code = ffa_pkg::STAT_ZERO;
                            state_next   = S_RESULT;
                        end
                        else if (sts.size_big)
                        begin
                            cmd.res_load = 1'b1;
                            cmd.res_code = ffa_pkg::STAT_NO_ROOM;
                            state_next   = S_RESULT;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    else if (sts.where_oob)
                    begin
                        cmd.res_load = 1'b1;
                        cmd.res_code = ffa_pkg::STAT_RANGE;
                        state_next   = S_RESULT;
                    end
                    else
                    begin
                        state_next = S_RLOOK;
                    end
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                priority if (sts.found)
                begin
                    state_next = S_MARK;
                end
                else if (sts.exhausted)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_code = ffa_pkg::STAT_NO_ROOM;
                    state_next   = S_RESULT;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_MARK:
            begin
                cmd.mark = 1'b1;
                if (sts.mark_last)
                begin
                    cmd.res_load      = 1'b1;
                    cmd.res_code      = ffa_pkg::STAT_DONE;
                    cmd.res_use_start = 1'b1;
                    state_next        = S_RESULT;
                end
            end
            S_RLOOK:
            begin
                cmd.rlook  = 1'b1;
                state_next = S_RWAIT;
            end
            S_RWAIT:
            begin
                if (sts.is_head)
                begin
                    cmd.rhead  = 1'b1;
                    state_next = S_RFREE;
                end
                else
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_code = ffa_pkg::STAT_NOT_HEAD;
                    state_next   = S_RESULT;
                end
            end
            S_RFREE:
            begin
                cmd.rfree = 1'b1;
                if (sts.free_last)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_code = ffa_pkg::STAT_DONE;
                    state_next   = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

>>> src/ffa_datapath.sv
module ffa_datapath #(
    parameter int POOL_CELLS = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ffa_pkg::cmd_t                  cmd,
    output ffa_pkg::sts_t                  sts,
    input  logic [ffa_pkg::SIZE_W-1:0]     req_size,
    input  logic [ffa_pkg::SIZE_W-1:0]     block_start,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [ffa_pkg::INDEX_W-1:0]    result_index,
    output logic [ffa_pkg::STATUS_W-1:0]   status
);

    localparam int IDX_W = $clog2(POOL_CELLS);
    localparam int CNT_W = $clog2(POOL_CELLS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POOL_CELLS - 1);

    // Cursor over the cell map, shared by clear, scan, mark and release.
    logic [CNT_W-1:0]            cur_reg, cur_next;
    logic [IDX_W-1:0]            chk_reg, chk_next;
    logic                        pend_reg, pend_next;
    logic [CNT_W-1:0]            run_reg, run_next;
    logic [IDX_W-1:0]            start_reg, start_next;
    logic [ffa_pkg::SIZE_W-1:0]  size_reg, size_next;
    logic [ffa_pkg::SIZE_W-1:0]  where_reg, where_next;
    logic [ffa_pkg::CELL_W-1:0]  rem_reg, rem_next;
    logic                        head_reg, head_next;
    ffa_pkg::status_t            pst_reg, pst_next;
    logic [ffa_pkg::INDEX_W-1:0] pidx_reg, pidx_next;
    ffa_pkg::status_t            ost_reg, ost_next;
    logic [ffa_pkg::INDEX_W-1:0] oidx_reg, oidx_next;
    logic                        oval_reg, oval_next;

    logic                        wr_en;
    logic [IDX_W-1:0]            wr_addr;
    logic [ffa_pkg::CELL_W-1:0]  wr_data;
    logic                        rd_en;
    logic [IDX_W-1:0]            rd_addr;
    logic [ffa_pkg::CELL_W-1:0]  rd_data;

    logic                        scan_rd;
    logic [CNT_W-1:0]            run_inc;
    logic                        cell_free;
    logic                        found_w;
    logic [IDX_W-1:0]            start_calc;

    ffa_ram #(
        .WIDTH (ffa_pkg::CELL_W),
        .DEPTH (POOL_CELLS)
    ) u_cell_map (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Scan read issue and run-length check of the cell read last cycle.
    assign scan_rd    = cmd.scan && (cur_reg < CNT_W'(POOL_CELLS));
    assign run_inc    = run_reg + CNT_W'(1);
    assign cell_free  = (rd_data == ffa_pkg::CELL_FREE);
    assign found_w    = cmd.scan && pend_reg && cell_free
                        && (32'(run_inc) >= 32'(size_reg));
    assign start_calc = IDX_W'(32'(chk_reg) + 32'd1 - 32'(size_reg));

    // Memory port selection.
    assign wr_en   = cmd.clear || cmd.mark || cmd.rfree;
    assign wr_addr = cur_reg[IDX_W-1:0];
    assign wr_data = cmd.mark ? (head_reg ? ffa_pkg::CELL_W'(size_reg) : ffa_pkg::CELL_CONT)
                              : ffa_pkg::CELL_FREE;
    assign rd_en   = scan_rd || cmd.rlook;
    assign rd_addr = cmd.rlook ? IDX_W'(where_reg) : cur_reg[IDX_W-1:0];

    // Status toward the controller.
    always_comb
    begin
        sts           = '0;
        sts.clr_last  = (cur_reg[IDX_W-1:0] == LAST_IDX);
        sts.size_zero = (req_size == '0);
        sts.size_big  = (32'(req_size) > 32'(POOL_CELLS));
        sts.where_oob = (32'(block_start) >= 32'(POOL_CELLS));
        sts.found     = found_w;
        sts.exhausted = cmd.scan && pend_reg && !found_w && (chk_reg == LAST_IDX);
        sts.mark_last = (rem_reg == ffa_pkg::CELL_W'(1));
        sts.is_head   = (rd_data != ffa_pkg::CELL_FREE) && (rd_data != ffa_pkg::CELL_CONT);
        sts.free_last = (rem_reg == ffa_pkg::CELL_W'(1))
                        || (cur_reg[IDX_W-1:0] == LAST_IDX);
        sts.out_free  = !oval_reg || out_ready;
    end

    // Next values of the datapath registers.
    always_comb
    begin
        cur_next   = cur_reg;
        chk_next   = chk_reg;
        pend_next  = pend_reg;
        run_next   = run_reg;
        start_next = start_reg;
        size_next  = size_reg;
        where_next = where_reg;
        rem_next   = rem_reg;
        head_next  = head_reg;
        pst_next   = pst_reg;
        pidx_next  = pidx_reg;
        ost_next   = ost_reg;
        oidx_next  = oidx_reg;
        oval_next  = oval_reg;

        if (cmd.clear)
        begin
            cur_next = cur_reg + CNT_W'(1);
        end

        if (cmd.accept)
        begin
            size_next  = req_size;
            where_next = block_start;
            cur_next   = '0;
            run_next   = '0;
            pend_next  = 1'b0;
        end

        if (cmd.scan)
        begin
            pend_next = scan_rd;
            if (scan_rd)
            begin
                chk_next = cur_reg[IDX_W-1:0];
                cur_next = cur_reg + CNT_W'(1);
            end
            if (pend_reg)
            begin
                run_next = cell_free ? run_inc : '0;
            end
            if (found_w)
            begin
                start_next = start_calc;
                cur_next   = CNT_W'(start_calc);
                rem_next   = ffa_pkg::CELL_W'(size_reg);
                head_next  = 1'b1;
            end
        end

        if (cmd.mark || cmd.rfree)
        begin
            cur_next  = cur_reg + CNT_W'(1);
            rem_next  = rem_reg - ffa_pkg::CELL_W'(1);
            head_next = 1'b0;
        end

        if (cmd.rlook)
        begin
            cur_next = CNT_W'(where_reg);
        end

        if (cmd.rhead)
        begin
            rem_next = rd_data;
        end

        if (cmd.res_load)
        begin
            pst_next  = cmd.res_code;
            pidx_next = cmd.res_use_start ? ffa_pkg::INDEX_W'(start_reg) : '0;
        end

        // Output register: a new result may load in the cycle the old one leaves.
        if (oval_reg && out_ready)
        begin
            oval_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            oval_next = 1'b1;
            ost_next  = pst_reg;
            oidx_next = pidx_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg  <= '0;
            pend_reg <= 1'b0;
            head_reg <= 1'b0;
            oval_reg <= 1'b0;
        end
        else
        begin
            cur_reg  <= cur_next;
            pend_reg <= pend_next;
            head_reg <= head_next;
            oval_reg <= oval_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        chk_reg   <= chk_next;
        run_reg   <= run_next;
        start_reg <= start_next;
        size_reg  <= size_next;
        where_reg <= where_next;
        rem_reg   <= rem_next;
        pst_reg   <= pst_next;
        pidx_reg  <= pidx_next;
        ost_reg   <= ost_next;
        oidx_reg  <= oidx_next;
    end

    assign out_valid    = oval_reg;
    assign result_index = oidx_reg;
    assign status       = ost_reg;

`ifndef SYNTHESIS
    // A successful scan is followed by the head write of the new block.
    a_found_then_head: assert property (@(posedge clk) disable iff (!rst_n)
        found_w |=> (cmd.mark && head_reg))
        else $error("scan hit not followed by head write");

    // Marking never runs past the end of the pool.
    a_mark_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mark |-> (cur_reg < CNT_W'(POOL_CELLS)))
        else $error("mark cursor beyond pool");

    // A release only frees cells while some remain of the block.
    a_free_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rfree |-> (rem_reg != '0))
        else $error("release with empty count");

    // A head read during release always lies inside the pool.
    a_release_index: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rlook |-> (32'(where_reg) < 32'(POOL_CELLS)))
        else $error("release lookup out of range");
`endif

endmodule

>>> src/first_fit_cell_allocator.sv
// First-fit cell allocator.
// Input channel (in_valid/in_ready) takes one request item: op selects
// allocate or release, req_size is the cell count for allocate and
// block_start the head cell for release. Output channel (out_valid/out_ready)
// returns one item per request: result_index and status.
// Allocate scans the cell map one cell per cycle through the cell map RAM's
// single read port, then writes the block one cell per cycle through its
// write port. A scan that finds no room answers once it has checked the last
// cell. Zero size, oversize and out-of-range requests answer without touching
// the cell map. Release reads the head cell, then frees the cells of the
// block; at a cell that is no block head it answers without freeing any.
// One request is in work at a time; in_ready rises again in the cycle the
// result goes valid.
// After reset the block clears the cell map, one cell per cycle, before
// in_ready rises.
// The result sits in an output register; while the receiver stalls it holds,
// and the next request may be accepted and processed meanwhile, waiting
// only at its own result hand-off.
module first_fit_cell_allocator #(
    parameter int POOL_CELLS = 256
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         op,
    input  logic [ffa_pkg::SIZE_W-1:0]   req_size,
    input  logic [ffa_pkg::SIZE_W-1:0]   block_start,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [ffa_pkg::INDEX_W-1:0]  result_index,
    output logic [ffa_pkg::STATUS_W-1:0] status
);

    ffa_pkg::cmd_t cmd;
    ffa_pkg::sts_t sts;

    ffa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .op       (op),
        .sts      (sts),
        .cmd      (cmd)
    );

    ffa_datapath #(
        .POOL_CELLS (POOL_CELLS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .req_size     (req_size),
        .block_start  (block_start),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_index (result_index),
        .status       (status)
    );

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int POOL_CELLS = 256;
    // The longest request scans and marks the whole pool; stalls come on top.
    localparam int BLOCK_LATENCY = 2 * POOL_CELLS + 16;
    localparam int IDLE_LIMIT = 8000;
    localparam int RANDOM_ITEMS = 900;

    // Expected content of one result item.
    typedef struct {
        logic [ffa_pkg::INDEX_W-1:0] index;
        ffa_pkg::status_t            code;
    } alloc_result_t;

    // Tracks the cell pool as the block should see it and the results owed.
    class cell_pool_tracker;
        logic [ffa_pkg::CELL_W-1:0] cell_map [POOL_CELLS];
        alloc_result_t              pending_results [$];

        function new();
            foreach (cell_map[i])
            begin
                cell_map[i] = ffa_pkg::CELL_FREE;
            end
        endfunction

        // Applies one accepted request to the pool and queues its result.
        function void predict_request(logic kind, logic [ffa_pkg::SIZE_W-1:0] cells,
                                      logic [ffa_pkg::SIZE_W-1:0] at);
            alloc_result_t r;
            int run;
            int first;
            int len;
            r.index = '0;
            r.code  = ffa_pkg::STAT_DONE;
            if (kind == ffa_pkg::OP_ALLOC)
            begin
                if (cells == 0)
                begin
                    r.code = ffa_pkg::STAT_ZERO;
                end
                else
                begin
                    // First fit: lowest start with enough free cells after it.
                    run   = 0;
                    first = -1;
                    for (int i = 0; i < POOL_CELLS && first < 0; i++)
                    begin
                        if (cell_map[i] == ffa_pkg::CELL_FREE)
                        begin
                            run++;
                            if (run >= cells)
                                first = i + 1 - int'(cells);
                        end
                        else
                        begin
                            run = 0;
                        end
                    end
                    if (first < 0)
                    begin
                        r.code = ffa_pkg::STAT_NO_ROOM;
                    end
                    else
                    begin
                        cell_map[first] = ffa_pkg::CELL_W'(cells);
                        for (int i = 1; i < cells; i++)
                            cell_map[first + i] = ffa_pkg::CELL_CONT;
                        r.index = ffa_pkg::INDEX_W'(first);
                    end
                end
            end
            else
            begin
                if (at >= POOL_CELLS)
                begin
                    r.code = ffa_pkg::STAT_RANGE;
                end
                else
                begin
                    len = cell_map[at];
                    if (cell_map[at] == ffa_pkg::CELL_FREE
                        || cell_map[at] == ffa_pkg::CELL_CONT)
                    begin
                        r.code = ffa_pkg::STAT_NOT_HEAD;
                    end
                    else
                    begin
                        for (int i = 0; i < len && int'(at) + i < POOL_CELLS; i++)
                            cell_map[int'(at) + i] = ffa_pkg::CELL_FREE;
                    end
                end
            end
            pending_results.push_back(r);
        endfunction

        // Returns a random live block head, or -1 when the pool is empty.
        function int pick_live_head();
            int heads [$];
            foreach (cell_map[i])
            begin
                if (cell_map[i] != ffa_pkg::CELL_FREE && cell_map[i] != ffa_pkg::CELL_CONT)
                    heads.push_back(i);
            end
            if (heads.size() == 0)
                return -1;
            return heads[$urandom_range(0, heads.size() - 1)];
        endfunction

        // Compares one result with the oldest one owed; empty string if it matches.
        function string match_result(logic [ffa_pkg::INDEX_W-1:0] index,
                                     logic [ffa_pkg::STATUS_W-1:0] code);
            alloc_result_t r;
            if (pending_results.size() == 0)
                return $sformatf("result index %0d status %0d with no request open",
                                 index, code);
            r = pending_results.pop_front();
            if (index !== r.index || code !== r.code)
                return $sformatf("got index %0d status %0d, wanted index %0d status %0d",
                                 index, code, r.index, r.code);
            return "";
        endfunction
    endclass

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_ready;
    logic                         op = ffa_pkg::OP_ALLOC;
    logic [ffa_pkg::SIZE_W-1:0]   req_size = '0;
    logic [ffa_pkg::SIZE_W-1:0]   block_start = '0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic [ffa_pkg::INDEX_W-1:0]  result_index;
    logic [ffa_pkg::STATUS_W-1:0] status;

    cell_pool_tracker pool;
    int               mismatches = 0;
    int               idle_cycles = 0;
    int               stall_mode = 0;
    int               stall_phase = 0;
    string            msg;

    first_fit_cell_allocator #(
        .POOL_CELLS(POOL_CELLS)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .op(op),
        .req_size(req_size),
        .block_start(block_start),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .result_index(result_index),
        .status(status)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string what);
        $display("tb: mismatch at %0t ns: %s", $time, what);
        mismatches++;
    endtask

    // Presents one item and holds it until the block takes it.
    task automatic send_request(input logic kind, input logic [ffa_pkg::SIZE_W-1:0] cells,
                                input logic [ffa_pkg::SIZE_W-1:0] at);
        @(negedge clk);
        in_valid    <= 1'b1;
        op          <= kind;
        req_size    <= cells;
        block_start <= at;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pool.predict_request(kind, cells, at);
    endtask

    // Drops valid for a number of cycles.
    task automatic hold_off(input int cycles);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (cycles - 1)
            @(negedge clk);
    endtask

    task automatic wait_results_drained();
        while (pool.pending_results.size() != 0)
            @(posedge clk);
    endtask

    // One random item: mostly small allocations and releases of live blocks,
    // with some oversize, zero-size and stray releases mixed in.
    task automatic random_request();
        int                         pick;
        int                         head;
        logic                       kind;
        logic [ffa_pkg::SIZE_W-1:0] cells;
        logic [ffa_pkg::SIZE_W-1:0] at;
        pick  = $urandom_range(0, 99);
        head  = pool.pick_live_head();
        cells = ffa_pkg::SIZE_W'($urandom_range(0, 511));
        at    = ffa_pkg::SIZE_W'($urandom_range(0, 511));
        if (pick < 48)
        begin
            kind = ffa_pkg::OP_ALLOC;
            pick = $urandom_range(0, 99);
            if (pick < 70)
                cells = ffa_pkg::SIZE_W'($urandom_range(1, 8));
            else if (pick < 90)
                cells = ffa_pkg::SIZE_W'($urandom_range(9, 48));
            else if (pick < 96)
                cells = ffa_pkg::SIZE_W'($urandom_range(49, 256));
            else if (pick < 98)
                cells = ffa_pkg::SIZE_W'($urandom_range(257, 511));
            else
                cells = '0;
        end
        else if (pick < 88 && head >= 0)
        begin
            kind = ffa_pkg::OP_RELEASE;
            at   = ffa_pkg::SIZE_W'(head);
        end
        else
        begin
            kind = ffa_pkg::OP_RELEASE;
            if ($urandom_range(0, 1) == 0)
                at = ffa_pkg::SIZE_W'($urandom_range(0, POOL_CELLS - 1));
        end
        send_request(kind, cells, at);
    endtask

    // Receiver readiness follows a mode that is redrawn at random intervals.
    always @(negedge clk)
    begin
        if (stall_phase == 0)
        begin
            stall_mode  <= $urandom_range(0, 3);
            stall_phase <= $urandom_range(16, 96);
        end
        else
        begin
            stall_phase <= stall_phase - 1;
        end
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: out_ready <= (stall_phase[3:0] == 4'd0);
            default: out_ready <= (stall_phase[1:0] != 2'd0);
        endcase
    end

    // Each result taken is checked against the oldest one owed.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            msg = pool.match_result(result_index, status);
            if (msg != "")
                report_mismatch(msg);
        end
    end

    // Ends the run if neither channel moves for too long.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        int sent;
        int burst;
        pool = new();
        sent = 0;
        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed items: special statuses, full pool, top cell, first-fit gap.
        send_request(ffa_pkg::OP_ALLOC, 9'd0, 9'd0);
        send_request(ffa_pkg::OP_RELEASE, 9'd0, 9'd0);
        send_request(ffa_pkg::OP_RELEASE, 9'd0, 9'd256);
        send_request(ffa_pkg::OP_RELEASE, 9'd511, 9'd511);
        send_request(ffa_pkg::OP_ALLOC, 9'd1, 9'd0);
        send_request(ffa_pkg::OP_ALLOC, 9'd3, 9'd0);
        send_request(ffa_pkg::OP_RELEASE, 9'd0, 9'd2);
        send_request(ffa_pkg::OP_ALLOC, 9'd256, 9'd0);
        send_request(ffa_pkg::OP_ALLOC, 9'd511, 9'd0);
        send_request(ffa_pkg::OP_ALLOC, 9'd257, 9'd0);
        send_request(ffa_pkg::OP_RELEASE, 9'd0, 9'd0);
        send_request(ffa_pkg::OP_RELEASE, 9'd0, 9'd1);
        send_request(ffa_pkg::OP_ALLOC, 9'd256, 9'd0);
        send_request(ffa_pkg::OP_ALLOC, 9'd1, 9'd0);
        send_request(ffa_pkg::OP_RELEASE, 9'd0, 9'd0);
        send_request(ffa_pkg::OP_ALLOC, 9'd255, 9'd0);
        send_request(ffa_pkg::OP_ALLOC, 9'd1, 9'd0);
        send_request(ffa_pkg::OP_RELEASE, 9'd0, 9'd255);
        send_request(ffa_pkg::OP_RELEASE, 9'd0, 9'd0);
        send_request(ffa_pkg::OP_ALLOC, 9'd2, 9'd0);
        send_request(ffa_pkg::OP_ALLOC, 9'd2, 9'd0);
        send_request(ffa_pkg::OP_RELEASE, 9'd0, 9'd0);
        send_request(ffa_pkg::OP_ALLOC, 9'd1, 9'd0);
        send_request(ffa_pkg::OP_ALLOC, 9'd2, 9'd0);

        // Random items in bursts separated by gaps of random length.
        while (sent < RANDOM_ITEMS)
        begin
            burst = $urandom_range(1, 24);
            for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++)
            begin
                random_request();
                sent++;
                // Halfway through, let every owed result come back first.
                if (sent == RANDOM_ITEMS / 2)
                begin
                    hold_off(1);
                    wait_results_drained();
                end
            end
            if ($urandom_range(0, 3) != 0)
                hold_off($urandom_range(1, 16));
        end

        hold_off(1);
        wait_results_drained();
        repeat (BLOCK_LATENCY)
            @(posedge clk);
        if (pool.pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never came",
                                      pool.pending_results.size()));
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
